[src/soft_audio_sample_mix_assert.svh]
// Assertion macros for the sample mixer.
`ifndef SOFT_AUDIO_SAMPLE_MIX_ASSERT_SVH
`define SOFT_AUDIO_SAMPLE_MIX_ASSERT_SVH

// Clocked check, muted during reset.
`define SASM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SASM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SASM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[src/sasm_pkg.sv]
package sasm_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned WideW    = 64;
  localparam int unsigned DivSteps = WideW;

  localparam logic [1:0] CfgSampleBytes = 2'd0;
  localparam logic [1:0] CfgSampleBits  = 2'd1;

  localparam logic [2:0] MaxSampleBytes = 3'd4;
  localparam logic [7:0] SignByte       = 8'h80;

  typedef struct packed {
    logic [WideW-1:0] num_mag;
    logic             neg;
    logic [2:0]       nb;
    logic [WordW-1:0] full;
  } tag_t;

  function automatic logic [WordW-1:0] byte_mask(input logic [2:0] nb);
    logic [WordW-1:0] m;
    case (nb)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [WordW-1:0] sign_mark(input logic [2:0] nb);
    logic [WordW-1:0] m;
    case (nb)
      3'd1:    m = {24'd0, SignByte};
      3'd2:    m = {16'd0, SignByte, 8'd0};
      3'd3:    m = {8'd0, SignByte, 16'd0};
      default: m = {SignByte, 24'd0};
    endcase
    return m;
  endfunction

  function automatic logic signed [WordW:0] sext(input logic [WordW-1:0] w,
                                                 input logic [2:0] nb);
    logic signed [WordW:0] v;
    case (nb)
      3'd1:    v = {{25{w[7]}}, w[7:0]};
      3'd2:    v = {{17{w[15]}}, w[15:0]};
      3'd3:    v = {{9{w[23]}}, w[23:0]};
      default: v = {w[31], w};
    endcase
    return v;
  endfunction

endpackage

[src/sasm_div.sv]
module sasm_div import sasm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_vld_i,
  input  logic [WideW-1:0] dvd_i,
  input  logic [WideW-1:0] dsr_i,
  input  tag_t             tag_i,
  output logic             out_vld_o,
  output logic [WideW-1:0] quo_o,
  output tag_t             tag_o
);

  logic             vld_q [DivSteps];
  logic [WideW-1:0] rem_q [DivSteps];
  logic [WideW-1:0] dvd_q [DivSteps];
  logic [WideW-1:0] dsr_q [DivSteps];
  logic [WideW-1:0] quo_q [DivSteps];
  tag_t             tag_q [DivSteps];

  // one quotient bit per stage, restoring
  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic             vld_s;
    logic [WideW-1:0] rem_s, dvd_s, dsr_s, quo_s;
    tag_t             tag_s;
    logic [WideW:0]   trial;
    logic [WideW:0]   diff;
    logic             take;

    if (s == 0) begin : g_first
      assign vld_s = in_vld_i;
      assign rem_s = '0;
      assign dvd_s = dvd_i;
      assign dsr_s = dsr_i;
      assign quo_s = '0;
      assign tag_s = tag_i;
    end else begin : g_next
      assign vld_s = vld_q[s-1];
      assign rem_s = rem_q[s-1];
      assign dvd_s = dvd_q[s-1];
      assign dsr_s = dsr_q[s-1];
      assign quo_s = quo_q[s-1];
      assign tag_s = tag_q[s-1];
    end

    assign trial = {rem_s, dvd_s[WideW-1]};
    assign diff  = trial - {1'b0, dsr_s};
    assign take  = trial >= {1'b0, dsr_s};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? diff[WideW-1:0] : trial[WideW-1:0];
      dvd_q[s] <= {dvd_s[WideW-2:0], 1'b0};
      dsr_q[s] <= dsr_s;
      quo_q[s] <= {quo_s[WideW-2:0], take};
      tag_q[s] <= tag_s;
    end
  end

  assign out_vld_o = vld_q[DivSteps-1];
  assign quo_o     = quo_q[DivSteps-1];
  assign tag_o     = tag_q[DivSteps-1];

endmodule

[src/soft_audio_sample_mix.sv]
// Nonlinear PCM mixer: mixes new_word_i into mix_word_i, one pair per transaction.
// Input: a transaction is taken at a clock edge with start_i high and busy_o low.
//   busy_o is always low, so a new pair may enter on every cycle.
// Output: done_o is high for exactly one cycle with mixed_word_o; the receiver
//   must take it then, it cannot stall the block. Results leave in input order.
// Pipeline: from the accepting edge to done_o the registers are the input
//   register, sign extension, multiply, 64-stage divider for |a*b|/F,
//   denominator add, 64-stage divider for the quotient, output format.
// Throughput: one pair per cycle, set by the two one-bit-per-stage dividers.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 sample
//   bytes, 1 sample bits) at once; write only while no pair is in flight.
// Reset: sample_bytes 2, sample_bits 16, pipeline emptied; no result follows.
`include "soft_audio_sample_mix_assert.svh"

module soft_audio_sample_mix import sasm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] mix_word_i,
  input  logic [31:0] new_word_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_data_i,
  output logic        done_o,
  output logic [31:0] mixed_word_o
);

  logic [2:0] sample_bytes_q;
  logic [5:0] sample_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bytes_q <= 3'd2;
      sample_bits_q  <= 6'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSampleBytes: sample_bytes_q <= cfg_data_i[2:0];
        CfgSampleBits:  sample_bits_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic       acc;
  logic [2:0] nb_d;
  logic [4:0] k_d;
  assign acc = start_i && !busy_o;

  always_comb begin
    nb_d = sample_bytes_q;
    if (sample_bytes_q == 3'd0) nb_d = 3'd1;
    else if (sample_bytes_q > MaxSampleBytes) nb_d = MaxSampleBytes;
    k_d = sample_bits_q[4:0] - 5'd1;
    if (sample_bits_q < 6'd2) k_d = 5'd1;
    else if (sample_bits_q > 6'd32) k_d = 5'd31;
  end

  // stage 0: capture
  logic        s0_vld_q;
  logic [31:0] s0_mix_q, s0_new_q;
  logic [2:0]  s0_nb_q;
  logic [4:0]  s0_k_q;

  // stage 1: widen
  logic        s1_vld_q;
  logic [31:0] s1_ma_q, s1_mb_q, s1_full_q;
  logic [32:0] s1_smag_q;
  logic        s1_neg_q;
  logic [2:0]  s1_nb_q;

  // stage 2: multiply
  logic        s2_vld_q;
  logic [63:0] s2_prod_q;
  tag_t        s2_tag_q;

  // denominator
  logic        dn_vld_q;
  logic [63:0] dn_den_q;
  tag_t        dn_tag_q;

  // output
  logic        out_vld_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_nb_q;

  logic signed [32:0] a_w, b_w;
  logic signed [33:0] sum_w;
  logic [31:0]        ma_w, mb_w;
  logic [32:0]        smag_w;
  logic [64:0]        nprod_w;

  always_comb begin
    a_w    = sext(s0_mix_q, s0_nb_q);
    b_w    = sext(s0_new_q, s0_nb_q);
    sum_w  = 34'(a_w) + 34'(b_w);
    ma_w   = a_w[32] ? 32'(-a_w) : a_w[31:0];
    mb_w   = b_w[32] ? 32'(-b_w) : b_w[31:0];
    smag_w = sum_w[33] ? 33'(-sum_w) : sum_w[32:0];
    nprod_w = 65'(s1_smag_q) * 65'(s1_full_q);
  end

  logic        d1_vld, d2_vld;
  logic [63:0] d1_quo, d2_quo;
  tag_t        d1_tag, d2_tag, s2_tag_d;

  assign s2_tag_d = '{num_mag: nprod_w[63:0], neg: s1_neg_q, nb: s1_nb_q, full: s1_full_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      dn_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s0_vld_q  <= acc;
      s1_vld_q  <= s0_vld_q;
      s2_vld_q  <= s1_vld_q;
      dn_vld_q  <= d1_vld;
      out_vld_q <= d2_vld;
    end
  end

  logic [31:0] q_lo, r_w;
  logic        rneg;
  always_comb begin
    q_lo = d2_quo[31:0];
    rneg = d2_tag.neg && (d2_quo != 64'd0);
    r_w  = rneg ? 32'(-q_lo) : q_lo;
    r_w  = r_w & byte_mask(d2_tag.nb);
    if (rneg) r_w = r_w | sign_mark(d2_tag.nb);
  end

  always_ff @(posedge clk_i) begin
    s0_mix_q  <= mix_word_i;
    s0_new_q  <= new_word_i;
    s0_nb_q   <= nb_d;
    s0_k_q    <= k_d;
    s1_ma_q   <= ma_w;
    s1_mb_q   <= mb_w;
    s1_smag_q <= smag_w;
    s1_neg_q  <= sum_w[33];
    s1_nb_q   <= s0_nb_q;
    s1_full_q <= (32'd1 << s0_k_q) - 32'd1;
    s2_prod_q <= 64'(s1_ma_q) * 64'(s1_mb_q);
    s2_tag_q  <= s2_tag_d;
    dn_den_q  <= 64'(d1_tag.full) + d1_quo;
    dn_tag_q  <= d1_tag;
    out_word_q <= r_w;
    out_nb_q   <= d2_tag.nb;
  end

  sasm_div u_div_ratio (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s2_vld_q),
    .dvd_i     (s2_prod_q),
    .dsr_i     (64'(s2_tag_q.full)),
    .tag_i     (s2_tag_q),
    .out_vld_o (d1_vld),
    .quo_o     (d1_quo),
    .tag_o     (d1_tag)
  );

  sasm_div u_div_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (dn_vld_q),
    .dvd_i     (dn_tag_q.num_mag),
    .dsr_i     (dn_den_q),
    .tag_i     (dn_tag_q),
    .out_vld_o (d2_vld),
    .quo_o     (d2_quo),
    .tag_o     (d2_tag)
  );

  assign done_o       = out_vld_q;
  assign mixed_word_o = out_word_q;

  `SASM_ASSERT(a_upper_zero, out_vld_q |-> ((out_word_q & ~byte_mask(out_nb_q)) == 32'd0), "bytes above sample size not zero")
  `SASM_ASSERT_NEXT(a_den_follows, d1_vld, dn_vld_q, "denominator stage lost a transaction")
  `SASM_ASSERT(a_den_nonzero, dn_vld_q |-> (dn_den_q != 64'd0), "zero denominator")
  `SASM_ASSERT(a_never_busy, !busy_o, "busy raised")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import sasm_pkg::*;

  class mix_scoreboard;
    logic [31:0] pending_q[$];
    logic [2:0]  bytes_reg;
    logic [5:0]  bits_reg;
    int          errors;

    function new();
      bytes_reg = 3'd2;
      bits_reg  = 6'd16;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] data);
      if (idx == CfgSampleBytes) bytes_reg = data[2:0];
      else if (idx == CfgSampleBits) bits_reg = data;
    endfunction

    function automatic longint widen(logic [31:0] w, int nb);
      longint v;
      v = longint'({32'd0, w}) & ((64'd1 << (8 * nb)) - 1);
      if (v[8 * nb - 1]) v = v - (64'sd1 << (8 * nb));
      return v;
    endfunction

    function automatic logic [31:0] mix_pair(logic [31:0] mw, logic [31:0] nw);
      int          nb, nbits;
      longint      full, a, b, den, num, r;
      logic [63:0] prod, w;
      nb    = (bytes_reg < 1) ? 1 : (bytes_reg > 4) ? 4 : bytes_reg;
      nbits = (bits_reg < 2) ? 2 : (bits_reg > 32) ? 32 : bits_reg;
      full  = (64'sd1 <<< (nbits - 1)) - 1;
      a     = widen(mw, nb);
      b     = widen(nw, nb);
      prod  = 64'((a < 0) ? -a : a) * 64'((b < 0) ? -b : b);
      den   = full + longint'(prod / 64'(full));
      num   = (a + b) * full;
      r     = num / den;
      w     = 64'(r) & ((64'd1 << (8 * nb)) - 1);
      if (r < 0) w = w | (64'h80 << (8 * (nb - 1)));
      return w[31:0];
    endfunction

    function void note_pair(logic [31:0] mw, logic [31:0] nw);
      pending_q.push_back(mix_pair(mw, nw));
    endfunction

    function void check_mixed(logic [31:0] got);
      logic [31:0] exp_w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      if (got !== exp_w) begin
        $display("%0t: mixed_word expected %h actual %h", $time, exp_w, got);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 133;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] mix_word_i = '0;
  logic [31:0] new_word_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [5:0]  cfg_data_i = '0;
  logic        done_o;
  logic [31:0] mixed_word_o;

  mix_scoreboard sb = new();
  bit idle_ok = 1'b1;

  always #4 clk_i = ~clk_i;

  soft_audio_sample_mix dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_mixed(mixed_word_o);
  end

  task automatic send_pair(logic [31:0] mw, logic [31:0] nw);
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    start_i    <= 1'b1;
    mix_word_i <= mw;
    new_word_i <= nw;
    do @(posedge clk_i); while (busy_o);
    sb.note_pair(mw, nw);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample(int nb);
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = 32'hFFFF_FFFF;
      2: w = 32'h1 << (8 * nb - 1);
      3: w = (32'h1 << (8 * nb - 1)) - 1;
      4: w = w & ((nb == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * nb)) - 1));
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    int nb, phase;
    logic [5:0] bsel [8];
    bsel = '{6'd0, 6'd1, 6'd2, 6'd8, 6'd16, 6'd31, 6'd32, 6'd63};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_pair(32'h0000_7FFF, 32'h0000_7FFF);
    send_pair(32'h0000_8000, 32'h0000_8000);
    send_pair(32'h0000_8000, 32'h0000_7FFF);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'h0000_0001);
    send_pair(32'hABCD_1234, 32'h5555_FFFF);
    drain();
    write_reg(CfgSampleBytes, 6'd4);
    write_reg(CfgSampleBits, 6'd32);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    write_reg(CfgSampleBytes, 6'd0);
    write_reg(CfgSampleBits, 6'd0);
    send_pair(32'hFFFF_FF7F, 32'h0000_0080);
    send_pair(32'h0000_00FF, 32'hFFFF_FF01);
    drain();
    write_reg(CfgSampleBytes, 6'd7);
    write_reg(CfgSampleBits, 6'd63);
    send_pair(32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(32'h1234_5678, 32'h8765_4321);
    drain();

    for (phase = 0; phase < 16; phase++) begin
      write_reg(CfgSampleBytes, 6'($urandom_range(0, 7)));
      write_reg(CfgSampleBits, ($urandom_range(0, 3) == 0) ? 6'($urandom()) :
                bsel[$urandom_range(0, 7)]);
      nb = (sb.bytes_reg < 1) ? 1 : (sb.bytes_reg > 4) ? 4 : sb.bytes_reg;
      idle_ok = (phase < 13);
      repeat (120) send_pair(rand_sample(nb), rand_sample(nb));
      drain();
    end

    repeat (LATENCY + 10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/sasm_pkg.sv
src/sasm_div.sv
src/soft_audio_sample_mix.sv
sim/tb_top.sv
